@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks that vanish in synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ src/sgs_pkg.sv @@
// ----------------------------------------------------------------------------
// sgs_pkg
// shared constants and types of the separable smoothing unit
// ----------------------------------------------------------------------------
`default_nettype none

package sgs_pkg;

    localparam int MAX_SIZE_DEF      = 64;
    localparam int MAX_SIDE_TAPS_DEF = 4;

    localparam int REQ_W    = 2;
    localparam int ADDR_W   = 6;
    localparam int SAMPLE_W = 24;
    localparam int DATA_W   = 32;
    localparam int SIZE_W   = 7;
    localparam int TAPS_W   = 3;
    localparam int WEIGHT_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int ACC_W    = 40;
    localparam int PROD_W   = 50;
    localparam int FRAC_SHIFT = 16;

    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RUN   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_SIZE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE_TAPS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_1    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_2    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_3    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_4    = 3'd5;

    localparam logic [SIZE_W-1:0]   RST_MATRIX_SIZE = 7'd64;
    localparam logic [TAPS_W-1:0]   RST_SIDE_TAPS   = 3'd3;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT_1    = 16'd39750;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT_2    = 16'd8869;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT_3    = 16'd728;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT_4    = 16'd22;

    // centre weight of one in q1.16
    localparam logic [WEIGHT_W:0] WEIGHT_ONE = 17'h10000;

    typedef struct packed {
        logic                tap_en;
        logic                clear;
        logic [WEIGHT_W:0]   weight;
    } mac_ctl_t;

endpackage

`default_nettype wire

@@ src/sgs_mac.sv @@
// ----------------------------------------------------------------------------
// sgs_mac
// weighted tap accumulator: multiply, truncate, sum and saturate
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sgs_mac
    import sgs_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire mac_ctl_t                 ctl,
    input  wire logic signed [DATA_W-1:0] rdata,
    output logic signed [DATA_W-1:0]      acc_sat
);

    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-64'sd2147483648);

    logic                      s1_valid_reg;
    logic [WEIGHT_W:0]         s1_weight_reg;
    logic                      s2_valid_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [PROD_W-1:0]  prod_shift;

    assign prod_next  = PROD_W'(rdata) * PROD_W'($signed({1'b0, s1_weight_reg}));
    assign prod_shift = prod_reg >>> FRAC_SHIFT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= ctl.tap_en;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_weight_reg <= ctl.weight;
        prod_reg      <= prod_next;
        if (ctl.clear)
            acc_reg <= '0;
        else if (s2_valid_reg)
            acc_reg <= acc_reg + ACC_W'(prod_shift);
    end

    always_comb
    begin
        if (acc_reg > SAT_MAX)
            acc_sat = DATA_W'(SAT_MAX);
        else if (acc_reg < SAT_MIN)
            acc_sat = DATA_W'(SAT_MIN);
        else
            acc_sat = DATA_W'(acc_reg);
    end

    `ASSERT_IMPLIES(a_clear_drained, clk, rst_n, ctl.clear, !s1_valid_reg && !s2_valid_reg, "accumulator cleared with taps in flight")

endmodule

`default_nettype wire

@@ src/separable_gaussian_smoother_2d_unit.sv @@
// ----------------------------------------------------------------------------
// separable_gaussian_smoother_2d_unit
// square sample matrix with in-place separable smoothing
// ----------------------------------------------------------------------------
// A write request's result is offered right after acceptance. A read
// request's data comes out of the synchronous matrix memory in the cycle
// after acceptance, and no request is accepted in between. A run request
// walks the matrix twice (rows into the scratch memory, then columns back),
// one memory read per tap, each output sample in turn through the issue,
// drain and write states; its pace is set by the single read port of each
// memory and the three-stage multiply and accumulate. No request is
// accepted during a run.
`default_nettype none
`include "assert_macros.svh"

module separable_gaussian_smoother_2d_unit
    import sgs_pkg::*;
#(
    parameter int MAX_SIZE      = MAX_SIZE_DEF,
    parameter int MAX_SIDE_TAPS = MAX_SIDE_TAPS_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_write_en,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [WEIGHT_W-1:0]        cfg_data,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [REQ_W-1:0]           req_type,
    input  wire logic [ADDR_W-1:0]          row,
    input  wire logic [ADDR_W-1:0]          col,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic signed [DATA_W-1:0]        read_data,
    output logic                            status
);

    localparam int AW    = $clog2(MAX_SIZE);
    localparam int SW    = $clog2(MAX_SIZE + 1);
    localparam int DEPTH = 1 << (2 * AW);
    localparam int TW    = $clog2(MAX_SIDE_TAPS + 1) + 1;
    localparam int PW    = ((AW > TW) ? AW : TW) + 2;
    localparam int CW    = (SW > SIZE_W) ? SW : SIZE_W;
    localparam int RW    = (SW > ADDR_W) ? SW : ADDR_W;
    localparam int XW    = (TW > TAPS_W) ? TW : TAPS_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_RDWAIT = 3'd1;
    localparam logic [2:0] ST_ISSUE  = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_WRITE  = 3'd4;

    // configuration
    logic [SIZE_W-1:0]   matrix_size_reg;
    logic [TAPS_W-1:0]   side_taps_reg;
    logic [WEIGHT_W-1:0] weight_1_reg;
    logic [WEIGHT_W-1:0] weight_2_reg;
    logic [WEIGHT_W-1:0] weight_3_reg;
    logic [WEIGHT_W-1:0] weight_4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matrix_size_reg <= RST_MATRIX_SIZE;
            side_taps_reg   <= RST_SIDE_TAPS;
            weight_1_reg    <= RST_WEIGHT_1;
            weight_2_reg    <= RST_WEIGHT_2;
            weight_3_reg    <= RST_WEIGHT_3;
            weight_4_reg    <= RST_WEIGHT_4;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_MATRIX_SIZE: matrix_size_reg <= cfg_data[SIZE_W-1:0];
                CFG_SIDE_TAPS:   side_taps_reg   <= cfg_data[TAPS_W-1:0];
                CFG_WEIGHT_1:    weight_1_reg    <= cfg_data;
                CFG_WEIGHT_2:    weight_2_reg    <= cfg_data;
                CFG_WEIGHT_3:    weight_3_reg    <= cfg_data;
                CFG_WEIGHT_4:    weight_4_reg    <= cfg_data;
                default:         ;
            endcase
        end
    end

    logic [SW-1:0] n_eff;
    logic [TW-1:0] t_eff;

    always_comb
    begin
        if (matrix_size_reg == '0)
            n_eff = SW'(1);
        else if (CW'(matrix_size_reg) > CW'(MAX_SIZE))
            n_eff = SW'(MAX_SIZE);
        else
            n_eff = SW'(matrix_size_reg);
        if (XW'(side_taps_reg) > XW'(MAX_SIDE_TAPS))
            t_eff = TW'(MAX_SIDE_TAPS);
        else
            t_eff = TW'(side_taps_reg);
    end

    // sequencer state
    logic [2:0]           state_reg, state_next;
    logic                 pass_reg, pass_next;
    logic [AW-1:0]        line_reg, line_next;
    logic [AW-1:0]        pos_reg, pos_next;
    logic signed [TW-1:0] d_reg, d_next;
    logic                 drain_reg, drain_next;
    logic                 out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] read_data_reg, read_data_next;
    logic                 status_reg, status_next;
    logic                 out_load;

    logic                 accept;
    logic                 addr_ok;
    logic [AW-1:0]        row_idx;
    logic [AW-1:0]        col_idx;
    logic                 ext_wr;
    logic                 ext_rd;
    logic                 run_start;
    logic signed [TW-1:0] d_first;
    logic signed [PW-1:0] tap_pos;
    logic                 tap_ok;
    logic [AW-1:0]        tap_idx;
    logic [TW-1:0]        mag;
    logic [WEIGHT_W:0]    w_sel;
    logic                 pos_last;
    logic                 line_last;

    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign addr_ok   = (RW'(row) < RW'(n_eff)) && (RW'(col) < RW'(n_eff));
    assign row_idx   = AW'(row);
    assign col_idx   = AW'(col);
    assign ext_wr    = accept && (req_type == REQ_WRITE) && addr_ok;
    assign ext_rd    = accept && (req_type == REQ_READ) && addr_ok;
    assign run_start = accept && (req_type == REQ_RUN);
    assign d_first   = -$signed(t_eff);

    assign tap_pos   = PW'($signed({1'b0, pos_reg})) + PW'(d_reg);
    assign tap_ok    = !tap_pos[PW-1] && (tap_pos[PW-2:0] < (PW-1)'(n_eff));
    assign tap_idx   = tap_pos[AW-1:0];
    assign mag       = d_reg[TW-1] ? TW'(-d_reg) : TW'(d_reg);
    assign pos_last  = (SW'(pos_reg) == n_eff - SW'(1));
    assign line_last = (SW'(line_reg) == n_eff - SW'(1));

    always_comb
    begin
        case (mag)
            TW'(0):  w_sel = WEIGHT_ONE;
            TW'(1):  w_sel = {1'b0, weight_1_reg};
            TW'(2):  w_sel = {1'b0, weight_2_reg};
            TW'(3):  w_sel = {1'b0, weight_3_reg};
            TW'(4):  w_sel = {1'b0, weight_4_reg};
            default: w_sel = '0;
        endcase
    end

    // memories
    logic signed [DATA_W-1:0] matrix_mem [DEPTH];
    logic signed [DATA_W-1:0] scratch_mem [DEPTH];
    logic signed [DATA_W-1:0] mat_rdata_reg;
    logic signed [DATA_W-1:0] scr_rdata_reg;
    logic signed [DATA_W-1:0] acc_sat;

    logic                 mat_we, mat_re, scr_we, scr_re;
    logic [2*AW-1:0]      mat_waddr, mat_raddr, scr_waddr, scr_raddr;
    logic signed [DATA_W-1:0] mat_wdata;

    assign mat_we    = ext_wr || ((state_reg == ST_WRITE) && pass_reg);
    assign mat_waddr = (state_reg == ST_WRITE) ? {pos_reg, line_reg} : {row_idx, col_idx};
    assign mat_wdata = (state_reg == ST_WRITE) ? acc_sat : DATA_W'(sample);
    assign mat_re    = ext_rd || ((state_reg == ST_ISSUE) && !pass_reg);
    assign mat_raddr = (state_reg == ST_ISSUE) ? {line_reg, tap_idx} : {row_idx, col_idx};
    assign scr_we    = (state_reg == ST_WRITE) && !pass_reg;
    assign scr_waddr = {line_reg, pos_reg};
    assign scr_re    = (state_reg == ST_ISSUE) && pass_reg;
    assign scr_raddr = {tap_idx, line_reg};

    always_ff @(posedge clk)
    begin
        if (mat_we)
            matrix_mem[mat_waddr] <= mat_wdata;
        if (mat_re)
            mat_rdata_reg <= matrix_mem[mat_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (scr_we)
            scratch_mem[scr_waddr] <= acc_sat;
        if (scr_re)
            scr_rdata_reg <= scratch_mem[scr_raddr];
    end

    mac_ctl_t mac_ctl;

    assign mac_ctl.tap_en = (state_reg == ST_ISSUE) && tap_ok;
    assign mac_ctl.clear  = (state_reg == ST_WRITE) || run_start;
    assign mac_ctl.weight = w_sel;

    sgs_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mac_ctl),
        .rdata   (pass_reg ? scr_rdata_reg : mat_rdata_reg),
        .acc_sat (acc_sat)
    );

    always_comb
    begin
        state_next     = state_reg;
        pass_next      = pass_reg;
        line_next      = line_reg;
        pos_next       = pos_reg;
        d_next         = d_reg;
        drain_next     = drain_reg;
        out_load       = 1'b0;
        read_data_next = '0;
        status_next    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req_type)
                        REQ_WRITE:
                        begin
                            out_load    = 1'b1;
                            status_next = !addr_ok;
                        end
                        REQ_READ:
                        begin
                            if (addr_ok)
                                state_next = ST_RDWAIT;
                            else
                            begin
                                out_load    = 1'b1;
                                status_next = 1'b1;
                            end
                        end
                        REQ_RUN:
                        begin
                            state_next = ST_ISSUE;
                            pass_next  = 1'b0;
                            line_next  = '0;
                            pos_next   = '0;
                            d_next     = d_first;
                        end
                        default:
                            out_load = 1'b1;
                    endcase
                end
            end
            ST_RDWAIT:
            begin
                out_load       = 1'b1;
                read_data_next = mat_rdata_reg;
                state_next     = ST_IDLE;
            end
            ST_ISSUE:
            begin
                if (d_reg == $signed(t_eff))
                begin
                    state_next = ST_DRAIN;
                    drain_next = 1'b0;
                end
                else
                    d_next = d_reg + TW'(1);
            end
            ST_DRAIN:
            begin
                if (drain_reg)
                    state_next = ST_WRITE;
                else
                    drain_next = 1'b1;
            end
            ST_WRITE:
            begin
                d_next     = d_first;
                state_next = ST_ISSUE;
                if (pos_last)
                begin
                    pos_next = '0;
                    if (line_last)
                    begin
                        line_next = '0;
                        if (pass_reg)
                        begin
                            state_next = ST_IDLE;
                            out_load   = 1'b1;
                        end
                        else
                            pass_next = 1'b1;
                    end
                    else
                        line_next = line_reg + AW'(1);
                end
                else
                    pos_next = pos_reg + AW'(1);
            end
            default:
                state_next = ST_IDLE;
        endcase
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pass_reg      <= 1'b0;
            line_reg      <= '0;
            pos_reg       <= '0;
            d_reg         <= '0;
            drain_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pass_reg      <= pass_next;
            line_reg      <= line_next;
            pos_reg       <= pos_next;
            d_reg         <= d_next;
            drain_reg     <= drain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            read_data_reg <= read_data_next;
            status_reg    <= status_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign status    = status_reg;

    `ASSERT_IMPLIES(a_load_free_slot, clk, rst_n, out_load, !out_valid_reg || out_ready, "result overwrites a waiting result")
    `ASSERT_NEXT(a_run_starts, clk, rst_n, run_start, state_reg == ST_ISSUE && !pass_reg, "run request did not start the row pass")

endmodule

`default_nettype wire
